// ===== hdl/mbag_pkg.sv =====
// ----------------------------------------------------------------------------
// mbag_pkg
// Shared constants, action codes and the result record of the bag table.
// ----------------------------------------------------------------------------
`default_nettype none

package mbag_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int ITEM_WIDTH_DEF = 16;

   localparam int ACTION_W     = 2;
   localparam int ITEM_FIELD_W = 16;
   localparam int FIELD5_W     = 5;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   typedef struct packed {
      logic                success;
      logic [FIELD5_W-1:0] frequency;
      logic [FIELD5_W-1:0] entry_count;
      logic                is_empty;
   } mbag_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/mbag_mem.sv =====
// ----------------------------------------------------------------------------
// mbag_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbag_mem #(
   parameter int DEPTH = 16,
   parameter int VAL_W = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [VAL_W-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [VAL_W-1:0]         rd_data
);

   logic [VAL_W-1:0] store_ff [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mbag_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbag_ctrl
// Scan sequencer: walks the live entries one per cycle, counts matches,
// then appends, swaps the last entry into the hit slot, reports, or clears.
// ----------------------------------------------------------------------------
`default_nettype none

module mbag_ctrl #(
   parameter int DEPTH = 16,
   parameter int VAL_W = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [mbag_pkg::ACTION_W-1:0]    action,
   input  wire logic [VAL_W-1:0]                 value,
   output logic                                  busy,
   output logic                                  rd_en,
   output logic      [$clog2(DEPTH)-1:0]         rd_addr,
   input  wire logic [VAL_W-1:0]                 rd_data,
   output logic                                  wr_en,
   output logic      [$clog2(DEPTH)-1:0]         wr_addr,
   output logic      [VAL_W-1:0]                 wr_data,
   output logic                                  done,
   output mbag_pkg::mbag_rsp_type                rsp
);

   import mbag_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WIDE_W = (CNT_W > FIELD5_W) ? CNT_W : FIELD5_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff,  state_in;
   logic [ACTION_W-1:0] act_ff,    act_in;
   logic [VAL_W-1:0]    value_ff,  value_in;
   logic [CNT_W-1:0]    count_ff,  count_in;
   logic [CNT_W-1:0]    freq_ff,   freq_in;
   logic                found_ff,  found_in;
   logic [ADDR_W-1:0]   hit_ff,    hit_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [VAL_W-1:0]    last_ff,   last_in;

   logic [CNT_W-1:0]  count_less;
   logic [ADDR_W-1:0] last_idx;
   logic [CNT_W-1:0]  freq_res;
   logic              ok;
   logic [WIDE_W-1:0] freq_wide;
   logic [WIDE_W-1:0] count_wide;

   assign count_less = count_ff - 1'b1;
   assign last_idx   = count_less[ADDR_W-1:0];
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      freq_in   = freq_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      rd_idx_in = rd_idx_ff;
      last_in   = last_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      done      = 1'b0;
      freq_res  = '0;
      ok        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in    = action;
               value_in  = value;
               freq_in   = '0;
               found_in  = 1'b0;
               hit_in    = '0;
               rd_idx_in = '0;
               if (action == ACT_CLEAR || count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_data == value_ff) begin
               freq_in = freq_ff + 1'b1;
               if (!found_ff) begin
                  found_in = 1'b1;
                  hit_in   = rd_idx_ff;
               end
            end
            if (rd_idx_ff == last_idx) begin
               last_in  = rd_data;
               state_in = ST_FINISH;
            end else begin
               rd_en     = 1'b1;
               rd_addr   = rd_idx_ff + 1'b1;
               rd_idx_in = rd_addr;
            end
         end
         ST_FINISH: begin
            done     = 1'b1;
            state_in = ST_IDLE;
            case (act_ff)
               ACT_ADD: begin
                  if (count_ff < CNT_W'(DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[ADDR_W-1:0];
                     wr_data  = value_ff;
                     count_in = count_ff + 1'b1;
                     freq_res = freq_ff + 1'b1;
                     ok       = 1'b1;
                  end else begin
                     freq_res = freq_ff;
                  end
               end
               ACT_REMOVE: begin
                  if (found_ff) begin
                     // last entry fills the hole
                     wr_en    = 1'b1;
                     wr_addr  = hit_ff;
                     wr_data  = last_ff;
                     count_in = count_less;
                     freq_res = freq_ff - 1'b1;
                     ok       = 1'b1;
                  end else begin
                     freq_res = freq_ff;
                  end
               end
               ACT_QUERY: begin
                  freq_res = freq_ff;
                  ok       = found_ff;
               end
               default: begin
                  count_in = '0;
                  freq_res = '0;
                  ok       = 1'b1;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign freq_wide  = WIDE_W'(freq_res);
   assign count_wide = WIDE_W'(count_in);

   always_comb begin
      rsp.success     = ok;
      rsp.frequency   = freq_wide[FIELD5_W-1:0];
      rsp.entry_count = count_wide[FIELD5_W-1:0];
      rsp.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      value_ff  <= value_in;
      freq_ff   <= freq_in;
      found_ff  <= found_in;
      hit_ff    <= hit_in;
      rd_idx_ff <= rd_idx_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

// ===== hdl/multiset_bag_table.sv =====
// ----------------------------------------------------------------------------
// multiset_bag_table
// Bounded unordered multiset: add, remove first match, query and clear.
// Response: rsp_strobe is registered from the sequencer's done pulse, which follows
//   a scan of every live entry (no scan for clear or an empty bag).
// Flow: one transaction at a time; busy holds off start through the
//   one-entry-per-cycle scan through the single read port of the store.
// Reset: clears the entry count and the sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module multiset_bag_table #(
   parameter int DEPTH      = mbag_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = mbag_pkg::ITEM_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [mbag_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [mbag_pkg::ITEM_FIELD_W-1:0]    req_item_value,
   output logic                                      rsp_strobe,
   output logic                                      rsp_success,
   output logic      [mbag_pkg::FIELD5_W-1:0]        rsp_frequency,
   output logic      [mbag_pkg::FIELD5_W-1:0]        rsp_entry_count,
   output logic                                      rsp_is_empty
);

   import mbag_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VAL_W  = (ITEM_WIDTH < ITEM_FIELD_W) ? ITEM_WIDTH : ITEM_FIELD_W;

   logic              accept;
   logic [VAL_W-1:0]  value;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VAL_W-1:0]  rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              done;
   mbag_rsp_type      rsp;

   logic              rsp_strobe_ff;
   mbag_rsp_type      rsp_ff;

   assign accept = start && !busy;
   assign value  = req_item_value[VAL_W-1:0];

   mbag_ctrl #(
      .DEPTH (DEPTH),
      .VAL_W (VAL_W)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .action  (req_action),
      .value   (value),
      .busy    (busy),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .done    (done),
      .rsp     (rsp)
   );

   mbag_mem #(
      .DEPTH (DEPTH),
      .VAL_W (VAL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_success     = rsp_ff.success;
   assign rsp_frequency   = rsp_ff.frequency;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_is_empty    = rsp_ff.is_empty;

endmodule

`default_nettype wire

// ===== hdl/mbag_checker.sv =====
// ----------------------------------------------------------------------------
// mbag_checker
// Port-level checks of the bag table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mbag_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic [mbag_pkg::FIELD5_W-1:0]    rsp_frequency,
   input wire logic [mbag_pkg::FIELD5_W-1:0]    rsp_entry_count,
   input wire logic                             rsp_is_empty
);

   import mbag_pkg::*;

   // empty flag agrees with the count
   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("is_empty disagrees with entry_count");

   // an empty bag holds no copies of anything
   a_empty_freq : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_is_empty |-> (rsp_frequency == '0))
      else $error("nonzero frequency in empty bag");

   // an accepted transaction makes the block busy
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("not busy after accept");

   // result strobes never come back to back
   a_strobe_gap : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

endmodule

bind multiset_bag_table mbag_checker u_mbag_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_frequency   (rsp_frequency),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

`default_nettype wire

// ===== sim/multiset_bag_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_bag_table_tb
// Drives add, remove, query and clear transactions into the bag table and
// keeps a shadow copy of the bag to predict each response. Directed tests
// cover the empty bag, a full bag, swap-on-remove and clear. Random traffic
// with values mostly from a small pool then follows, with and without sender gaps.
// ----------------------------------------------------------------------------

module multiset_bag_table_tb;
   import mbag_pkg::*;

   localparam int BAG_DEPTH = DEPTH_DEF;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic [ACTION_W-1:0]     req_action     = ACT_QUERY;
   logic [ITEM_FIELD_W-1:0] req_item_value = '0;
   logic                    busy;
   logic                    rsp_strobe;
   logic                    rsp_success;
   logic [FIELD5_W-1:0]     rsp_frequency;
   logic [FIELD5_W-1:0]     rsp_entry_count;
   logic                    rsp_is_empty;

   logic [ITEM_FIELD_W-1:0] bag_entries [BAG_DEPTH];
   int unsigned             bag_size = 0;
   mbag_rsp_type            pending_rsp_q [$];
   int unsigned             mismatch_count = 0;
   int unsigned             sender_idle_pct = 0;

   multiset_bag_table u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_item_value  (req_item_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_success     (rsp_success),
      .rsp_frequency   (rsp_frequency),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // shadow bag update and expected response
   function automatic mbag_rsp_type apply_bag_action(input logic [ACTION_W-1:0] act,
                                                     input logic [ITEM_FIELD_W-1:0] val);
      mbag_rsp_type r;
      int unsigned  hits;
      r    = '0;
      hits = 0;
      case (act)
         ACT_ADD: begin
            if (bag_size < BAG_DEPTH) begin
               bag_entries[bag_size] = val;
               bag_size++;
               r.success = 1'b1;
            end
         end
         ACT_REMOVE: begin
            for (int i = 0; i < bag_size; i++) begin
               if (bag_entries[i] == val) begin
                  bag_entries[i] = bag_entries[bag_size-1];
                  bag_size--;
                  r.success = 1'b1;
                  break;
               end
            end
         end
         ACT_CLEAR: begin
            bag_size  = 0;
            r.success = 1'b1;
         end
         default: ;
      endcase
      if (act != ACT_CLEAR) begin
         for (int i = 0; i < bag_size; i++) begin
            if (bag_entries[i] == val) hits++;
         end
      end
      if (act == ACT_QUERY) r.success = (hits != 0);
      r.frequency   = FIELD5_W'(hits);
      r.entry_count = FIELD5_W'(bag_size);
      r.is_empty    = (bag_size == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      mbag_rsp_type got;
      mbag_rsp_type want;
      got = '{rsp_success, rsp_frequency, rsp_entry_count, rsp_is_empty};
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected transaction succ=%0b freq=%0d cnt=%0d empty=%0b",
                        $realtime, got.success, got.frequency, got.entry_count,
                        got.is_empty);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.success !== want.success || got.frequency !== want.frequency ||
                got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch exp succ=%0b freq=%0d cnt=%0d empty=%0b",
                           $realtime, want.success, want.frequency, want.entry_count,
                           want.is_empty);
                  $display("   got succ=%0b freq=%0d cnt=%0d empty=%0b",
                           got.success, got.frequency, got.entry_count, got.is_empty);
               end
            end
         end
      end
   end

   task automatic send_bag_action(input logic [ACTION_W-1:0] act,
                                  input logic [ITEM_FIELD_W-1:0] val);
      int unsigned  gap;
      mbag_rsp_type exp_rsp;
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 20);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          = 1'b1;
      req_action     = act;
      req_item_value = val;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_rsp       = apply_bag_action(act, val);
      pending_rsp_q = {pending_rsp_q, exp_rsp};
   endtask

   task automatic test_basic_actions();
      send_bag_action(ACT_QUERY,  16'h1234);
      send_bag_action(ACT_REMOVE, 16'h1234);
      send_bag_action(ACT_ADD,    16'hFFFF);
      send_bag_action(ACT_ADD,    16'h0001);
      send_bag_action(ACT_ADD,    16'hFFFF);
      send_bag_action(ACT_REMOVE, 16'hFFFF);
      send_bag_action(ACT_QUERY,  16'hFFFF);
      send_bag_action(ACT_REMOVE, 16'h0002);
      send_bag_action(ACT_CLEAR,  16'hA5A5);
      send_bag_action(ACT_CLEAR,  16'h0000);
   endtask

   task automatic test_fill_to_capacity();
      repeat (BAG_DEPTH) send_bag_action(ACT_ADD, 16'h0000);
      send_bag_action(ACT_QUERY,  16'h0000);
      send_bag_action(ACT_ADD,    16'hFFFF);
      send_bag_action(ACT_REMOVE, 16'hFFFF);
      send_bag_action(ACT_REMOVE, 16'h0000);
      send_bag_action(ACT_ADD,    16'hFFFF);
      send_bag_action(ACT_QUERY,  16'hFFFF);
      send_bag_action(ACT_CLEAR,  16'hFFFF);
   endtask

   task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
      int unsigned             add_pct;
      int unsigned             pick;
      logic [ACTION_W-1:0]     act;
      logic [ITEM_FIELD_W-1:0] val;
      sender_idle_pct = idle_pct;
      add_pct         = 50;
      for (int n = 0; n < n_items; n++) begin
         // swing between filling and draining so the bag reaches full and empty
         if (n % 40 == 0) add_pct = $urandom_range(25, 70);
         pick = $urandom_range(99);
         if (pick < add_pct) act = ACT_ADD;
         else if (pick < add_pct + (95 - add_pct) / 2) act = ACT_REMOVE;
         else if (pick < 97) act = ACT_QUERY;
         else act = ACT_CLEAR;
         case ($urandom_range(7))
            0: val = 16'h0000;
            1: val = 16'hFFFF;
            2: val = 16'h5A5A;
            3: val = 16'h8001;
            4: val = 16'h00FF;
            default: val = 16'($urandom_range(16'hFFFF));
         endcase
         send_bag_action(act, val);
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_basic_actions();
      test_fill_to_capacity();
      test_random_traffic(200, 0);
      test_random_traffic(200, 45);
      test_random_traffic(200, 10);
      @(negedge clock);
      start = 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (BAG_DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
